// ===== hw/rtl/acal_pkg.sv =====
// Shared types and constants for the accelerometer offset calibration and magnitude block.
package acal_pkg;

  localparam int AXIS_W     = 16;
  localparam int SQ_W       = 2 * AXIS_W;
  localparam int SS_W       = SQ_W + 2;
  localparam int ROOT_W     = SS_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = SS_W / 2;
  localparam int ONE_G_W    = 15;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd16384;
  localparam logic [AXIS_W-1:0]  MAG_MAX     = 16'd56755;

  localparam logic [0:0] REG_ONE_G = 1'b0;

  typedef struct packed {
    logic busy;
    logic done;
  } acal_stat_t;

  typedef enum logic [4:0] {
    S_CAL  = 5'b00001,
    S_DIV  = 5'b00010,
    S_IDLE = 5'b00100,
    S_MAG  = 5'b01000,
    S_HOLD = 5'b10000
  } acal_state_t;

endpackage

// ===== hw/rtl/acal_div.sv =====
// Bit-serial restoring divider of a signed calibration sum by the constant sample count.
module acal_div
  import acal_pkg::*;
#(
  parameter int DIVISOR = 500,
  parameter int SUM_W   = 25
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  output logic [AXIS_W-1:0]       quot,
  output acal_stat_t              stat
);

  localparam int RW = $clog2(DIVISOR) + 1;
  localparam int CW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dvd_r;
  logic [RW-1:0]    rem_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RW:0]      rsh;
  logic [RW:0]      rdiff;
  logic             ge;
  logic [AXIS_W-1:0] q_mag;

  assign rsh   = {rem_r, dvd_r[SUM_W-1]};
  assign ge    = rsh >= (RW+1)'(DIVISOR);
  assign rdiff = rsh - (RW+1)'(DIVISOR);
  assign q_mag = dvd_r[AXIS_W-1:0];
  assign quot  = neg_r ? (~q_mag + 1'b1) : q_mag;
  assign stat  = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(SUM_W);
        neg_r  <= sum[SUM_W-1];
        dvd_r  <= sum[SUM_W-1] ? (~sum + 1'b1) : sum;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[SUM_W-2:0], ge};
        rem_r <= ge ? rdiff[RW-1:0] : rsh[RW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/acal_sqsum.sv =====
// Three-lane bit-serial squarer that sums the squares of the corrected axes.
module acal_sqsum
  import acal_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [AXIS_W-1:0] cx,
  input  logic signed [AXIS_W-1:0] cy,
  input  logic signed [AXIS_W-1:0] cz,
  output logic [SS_W-1:0]          ss,
  output acal_stat_t               stat
);

  localparam int NUM_AXES = 3;
  localparam int CW       = $clog2(AXIS_W + 1);

  logic [AXIS_W-1:0] a_r [NUM_AXES];
  logic [AXIS_W-1:0] m_r [NUM_AXES];
  logic [SQ_W-1:0]   p_r [NUM_AXES];
  logic [SQ_W-1:0]   p_nxt [NUM_AXES];
  logic [AXIS_W-1:0] abs_in [NUM_AXES];
  logic [AXIS_W-1:0] raw_in [NUM_AXES];
  logic [AXIS_W:0]   hi [NUM_AXES];
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              add_r;
  logic              done_r;
  logic [SS_W-1:0]   ss_r;

  assign raw_in[0] = cx;
  assign raw_in[1] = cy;
  assign raw_in[2] = cz;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      abs_in[k] = raw_in[k][AXIS_W-1] ? (~raw_in[k] + 1'b1) : raw_in[k];
      hi[k]     = {1'b0, p_r[k][SQ_W-1:AXIS_W]}
                + (m_r[k][0] ? {1'b0, a_r[k]} : '0);
      p_nxt[k]  = {hi[k], p_r[k][AXIS_W-1:1]};
    end
  end

  assign ss   = ss_r;
  assign stat = '{busy: busy_r | add_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(AXIS_W);
        for (int k = 0; k < NUM_AXES; k++) begin
          a_r[k] <= abs_in[k];
          m_r[k] <= abs_in[k];
          p_r[k] <= '0;
        end
      end else if (busy_r) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          p_r[k] <= p_nxt[k];
          m_r[k] <= m_r[k] >> 1;
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          add_r  <= 1'b1;
        end
      end else if (add_r) begin
        ss_r   <= SS_W'(p_r[0]) + SS_W'(p_r[1]) + SS_W'(p_r[2]);
        add_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/acal_sqrt.sv =====
// Digit-by-digit floor square root, two radicand bits per cycle.
module acal_sqrt
  import acal_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SS_W-1:0]   ss,
  output logic [AXIS_W-1:0] root,
  output acal_stat_t        stat
);

  localparam int CW = $clog2(SQRT_STEPS + 1);

  logic [SS_W-1:0]   v_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  rsh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  rdiff;
  logic              ge;

  assign rsh   = {rem_r, v_r[SS_W-1:SS_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = rsh >= trial;
  assign rdiff = rsh - trial;
  assign root  = root_r[AXIS_W-1:0];
  assign stat  = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(SQRT_STEPS);
        v_r    <= ss;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        v_r    <= {v_r[SS_W-3:0], 2'b00};
        rem_r  <= ge ? rdiff[REM_W-1:0] : rsh[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/accel_offset_cal_magnitude_top.sv =====
// Top level: offset calibration, correction and magnitude of three-axis accelerometer samples.
// After reset the first CAL_SAMPLES samples are taken one per cycle and summed per axis; they
// give no result. The per-axis offsets then come from bit-serial dividers; while they run no
// sample is taken, and one_g_counts, as it stood at the last calibration transfer, is
// removed from the Z offset. Each later sample gives one result: the corrected axes and the
// floor square root of their summed squares (magnitude in g, Q2.14). From transfer to result
// a sample passes through the correction registers, the one-bit-per-cycle squarer and its
// final add, and the two-bits-per-cycle root; the next sample is taken while a result still
// waits in the output register.
module accel_offset_cal_magnitude_top
  import acal_pkg::*;
#(
  parameter int CAL_SAMPLES = 500
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // accel_x, accel_y, accel_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,  // cal_x, cal_y, cal_z, magnitude
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SUM_W = $clog2(CAL_SAMPLES) + AXIS_W;
  localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;

  acal_state_t state_r, state_nxt;

  logic [ONE_G_W-1:0]       one_g_r;
  logic [ONE_G_W-1:0]       one_g_cal_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_z_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [AXIS_W-1:0]        off_x_r, off_y_r, off_z_r;
  logic signed [AXIS_W-1:0] cal_x_r, cal_y_r, cal_z_r;
  logic signed [AXIS_W-1:0] in_x, in_y, in_z;
  logic                     div_start_r;
  logic                     sq_start_r;
  logic [AXIS_W-1:0]        q_x, q_y, q_z;
  acal_stat_t               div_stat, div_stat_y, div_stat_z;
  acal_stat_t               sq_stat, rt_stat;
  logic [SS_W-1:0]          ss;
  logic [AXIS_W-1:0]        root;
  logic                     in_acc, out_free, last_cal, load_out, cfg_wr;
  logic                     out_valid_r;
  logic [63:0]              out_data_r;

  assign in_x = in_tdata[15:0];
  assign in_y = in_tdata[31:16];
  assign in_z = in_tdata[47:32];

  assign in_tready  = (state_r == S_CAL) || (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign last_cal   = cnt_r == CNT_W'(CAL_SAMPLES - 1);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                   && (cfg_paddr[CFG_ADDR_W-1] == REG_ONE_G);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_ONE_G)
                    ? CFG_DATA_W'(one_g_r) : '0;

  assign load_out = ((state_r == S_MAG) && rt_stat.done && out_free)
                 || ((state_r == S_HOLD) && out_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CAL:  if (in_acc && last_cal) state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_IDLE;
      S_IDLE: if (in_acc) state_nxt = S_MAG;
      S_MAG:  if (rt_stat.done) state_nxt = out_free ? S_IDLE : S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CAL;
      one_g_r     <= ONE_G_RESET;
      one_g_cal_r <= ONE_G_RESET;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      cnt_r       <= '0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      off_z_r     <= '0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= in_acc && (state_r == S_CAL) && last_cal;
      sq_start_r  <= in_acc && (state_r == S_IDLE);
      if (cfg_wr) begin
        one_g_r <= cfg_pwdata[ONE_G_W-1:0];
      end
      if (in_acc && (state_r == S_CAL)) begin
        sum_x_r <= sum_x_r + SUM_W'(in_x);
        sum_y_r <= sum_y_r + SUM_W'(in_y);
        sum_z_r <= sum_z_r + SUM_W'(in_z);
        cnt_r   <= cnt_r + 1'b1;
        if (last_cal) begin
          one_g_cal_r <= one_g_r;
        end
      end
      if ((state_r == S_DIV) && div_stat.done) begin
        off_x_r <= q_x;
        off_y_r <= q_y;
        off_z_r <= q_z - {1'b0, one_g_cal_r};
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (state_r == S_IDLE)) begin
      cal_x_r <= in_x - off_x_r;
      cal_y_r <= in_y - off_y_r;
      cal_z_r <= in_z - off_z_r;
    end
    if (load_out) begin
      out_data_r <= {root, cal_z_r, cal_y_r, cal_x_r};
    end
  end

  acal_div #(.DIVISOR(CAL_SAMPLES), .SUM_W(SUM_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .sum(sum_x_r),
    .quot(q_x), .stat(div_stat)
  );

  acal_div #(.DIVISOR(CAL_SAMPLES), .SUM_W(SUM_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .sum(sum_y_r),
    .quot(q_y), .stat(div_stat_y)
  );

  acal_div #(.DIVISOR(CAL_SAMPLES), .SUM_W(SUM_W)) u_div_z (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .sum(sum_z_r),
    .quot(q_z), .stat(div_stat_z)
  );

  acal_sqsum u_sqsum (
    .clk(clk), .rst_n(rst_n), .start(sq_start_r),
    .cx(cal_x_r), .cy(cal_y_r), .cz(cal_z_r),
    .ss(ss), .stat(sq_stat)
  );

  acal_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_stat.done), .ss(ss),
    .root(root), .stat(rt_stat)
  );

`ifndef SYNTH
  a_no_result_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CAL) |-> !out_tvalid)
    else $error("result produced during calibration");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:48] <= MAG_MAX))
    else $error("magnitude above largest possible root");

  a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!sq_stat.busy && !rt_stat.busy && !div_stat.busy))
    else $error("sample taken while an arithmetic unit is busy");

  a_div_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.done == div_stat_y.done) && (div_stat.done == div_stat_z.done))
    else $error("offset divider lanes out of step");

  a_div_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && div_stat.done) |=> in_tready)
    else $error("not ready after calibration");
`endif

endmodule
